/* sv/ipfmt_pkg.sv */
// ----------------------------------------------------------------------------
// IP address text formatter - shared package
// Types, character codes and helper functions used by the front end, the
// character sequencer and the top level.
// ----------------------------------------------------------------------------
package ipfmt_pkg;

    // Default queue depths (both must be at least 2)
    localparam int unsigned CMD_DEPTH = 2;
    localparam int unsigned OUT_DEPTH = 2;

    // Address family codes on the input
    localparam logic [1:0] FAM_V4 = 2'd1;
    localparam logic [1:0] FAM_V6 = 2'd2;

    // ASCII codes
    localparam logic [6:0] CH_NUL   = 7'h00;
    localparam logic [6:0] CH_COLON = 7'h3a;
    localparam logic [6:0] CH_DOT   = 7'h2e;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LC_A  = 7'h61;
    localparam logic [6:0] CH_LC_F  = 7'h66;

    // Index of the final character of the "::ffff:" prefix
    localparam logic [2:0] PRE_LAST = 3'd6;

    // Classified address kind
    typedef enum logic [1:0] {
        K_EMPTY,
        K_V4,
        K_V6,
        K_MAPPED
    } t_kind;

    // Sequencer states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_EMPTY,
        BS_PREFIX,
        BS_DCOLON,
        BS_HEX,
        BS_DEC,
        BS_SEP
    } t_bstate;

    // Classified command handed from the front end to the sequencer
    typedef struct packed {
        t_kind                kind;
        logic [127:0]         addr;       // v6 groups, group 0 in the top bits
        logic [0:3][11:0]     bcd;        // decimal digits of the dotted quad
        logic [0:3][1:0]      dstart;     // first printed decimal digit per byte
        logic [0:7][1:0]      hstart;     // first printed hex digit per group
        logic                 run_ok;     // a zero run of two or more groups
        logic [2:0]           run_start;
        logic [3:0]           run_end;    // first group after the run (0..8)
    } t_cmd;

    // One result character
    typedef struct packed {
        logic [6:0] text_char;
        logic       last_char;
        logic       empty_text;
    } t_res;

    // Byte to three BCD digits (shift and add-3)
    function automatic logic [11:0] dec_digits(input logic [7:0] v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
            if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
            if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
            s = s << 1;
        end
        return s[19:8];
    endfunction

    // Nibble to lower-case hex ASCII
    function automatic logic [6:0] hex_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) c = CH_ZERO + {3'd0, d};
        else           c = CH_LC_A + {3'd0, d - 4'd10};
        return c;
    endfunction

endpackage

/* sv/ipfmt_fifo.sv */
// ----------------------------------------------------------------------------
// IP address text formatter - small register queue
// First-in first-out buffer of DEPTH words that decouples producer and
// consumer; full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module ipfmt_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop) n_cnt = r_cnt + 1'b1;
        else if (!do_push && do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

/* sv/ipfmt_front.sv */
// ----------------------------------------------------------------------------
// IP address text formatter - classifier
// Decodes the family, detects the IPv4-mapped form, finds the longest zero
// run and precomputes leading-digit positions and decimal digits.
// ----------------------------------------------------------------------------
module ipfmt_front (
    input  logic [1:0]        i_address_family,
    input  logic [63:0]       i_addr_high,
    input  logic [63:0]       i_addr_low,
    output ipfmt_pkg::t_cmd   o_cmd
);

    logic [127:0]     addr;
    logic [0:7][15:0] grp;
    logic [31:0]      quad;
    logic [0:3][7:0]  qb;
    logic             mapped;
    logic [3:0]       cur_len;
    logic [2:0]       zrun_start;
    logic [3:0]       best_len;
    logic [2:0]       best_start;

    assign addr   = {i_addr_high, i_addr_low};
    assign grp    = addr;
    assign mapped = (addr[127:48] == '0) && (addr[47:32] == 16'hffff);

    // family decode
    always_comb begin
        unique case (i_address_family)
            ipfmt_pkg::FAM_V4: o_cmd.kind = ipfmt_pkg::K_V4;
            ipfmt_pkg::FAM_V6: o_cmd.kind = mapped ? ipfmt_pkg::K_MAPPED : ipfmt_pkg::K_V6;
            default:           o_cmd.kind = ipfmt_pkg::K_EMPTY;
        endcase
    end

    // dotted quad source: top word for IPv4, bottom word for the mapped form
    assign quad = (i_address_family == ipfmt_pkg::FAM_V4) ? addr[127:96] : addr[31:0];
    assign qb   = quad;

    // decimal digits and leading digit per byte
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            o_cmd.bcd[b] = ipfmt_pkg::dec_digits(qb[b]);
            if (qb[b] >= 8'd100)     o_cmd.dstart[b] = 2'd2;
            else if (qb[b] >= 8'd10) o_cmd.dstart[b] = 2'd1;
            else                     o_cmd.dstart[b] = 2'd0;
        end
    end

    // leading hex digit per group
    always_comb begin
        for (int g = 0; g < 8; g++) begin
            if (grp[g][15:12] != '0)     o_cmd.hstart[g] = 2'd3;
            else if (grp[g][11:8] != '0) o_cmd.hstart[g] = 2'd2;
            else if (grp[g][7:4] != '0)  o_cmd.hstart[g] = 2'd1;
            else                         o_cmd.hstart[g] = 2'd0;
        end
    end

    // longest zero run, first one wins a tie
    always_comb begin
        cur_len    = '0;
        zrun_start = '0;
        best_len   = '0;
        best_start = '0;
        for (int g = 0; g < 8; g++) begin
            if (grp[g] != '0) begin
                cur_len = '0;
            end else begin
                if (cur_len == '0) zrun_start = 3'(g);
                cur_len = cur_len + 4'd1;
                if (cur_len > best_len) begin
                    best_len   = cur_len;
                    best_start = zrun_start;
                end
            end
        end
    end

    assign o_cmd.addr      = addr;
    assign o_cmd.run_ok    = (best_len >= 4'd2);
    assign o_cmd.run_start = best_start;
    assign o_cmd.run_end   = {1'b0, best_start} + best_len;

endmodule

/* sv/ipfmt_back.sv */
// ----------------------------------------------------------------------------
// IP address text formatter - character sequencer
// Walks one classified command and produces one text character per cycle while the
// result queue is not full; the next command loads in the cycle that emits the final character.
// ----------------------------------------------------------------------------
module ipfmt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipfmt_pkg::t_cmd   i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  logic              i_out_full,
    output logic              o_out_push,
    output ipfmt_pkg::t_res   o_res
);

    ipfmt_pkg::t_bstate r_state, n_state;
    ipfmt_pkg::t_cmd    r_cmd;
    logic [2:0]         r_idx, n_idx;
    logic [1:0]         r_dig, n_dig;
    logic [2:0]         r_cnt, n_cnt;

    logic [0:7][15:0]   grp;
    logic [15:0]        cur_grp;
    logic [3:0]         nib;
    logic [11:0]        cur_bcd;
    logic [3:0]         dec;
    logic [2:0]         nxt;
    logic               step;
    logic               done;

    assign grp     = r_cmd.addr;
    assign cur_grp = grp[r_idx];
    assign nib     = cur_grp[{r_dig, 2'b00} +: 4];
    assign cur_bcd = r_cmd.bcd[r_idx[1:0]];
    assign dec     = cur_bcd[{r_dig, 2'b00} +: 4];
    assign nxt     = r_idx + 3'd1;
    assign step    = (r_state != ipfmt_pkg::BS_IDLE) && !i_out_full;

    // character and end-of-address outputs
    always_comb begin
        o_res.text_char  = ipfmt_pkg::CH_NUL;
        o_res.empty_text = 1'b0;
        done             = 1'b0;
        unique case (r_state)
            ipfmt_pkg::BS_IDLE: begin
            end
            ipfmt_pkg::BS_EMPTY: begin
                o_res.empty_text = 1'b1;
                done             = 1'b1;
            end
            ipfmt_pkg::BS_PREFIX: begin
                o_res.text_char = (r_cnt == 3'd0 || r_cnt == 3'd1 ||
                                   r_cnt == ipfmt_pkg::PRE_LAST) ?
                                  ipfmt_pkg::CH_COLON : ipfmt_pkg::CH_LC_F;
            end
            ipfmt_pkg::BS_DCOLON: begin
                o_res.text_char = ipfmt_pkg::CH_COLON;
                done            = (r_cnt == 3'd1) && (r_cmd.run_end == 4'd8);
            end
            ipfmt_pkg::BS_HEX: begin
                o_res.text_char = ipfmt_pkg::hex_char(nib);
                done            = (r_dig == 2'd0) && (r_idx == 3'd7);
            end
            ipfmt_pkg::BS_DEC: begin
                o_res.text_char = ipfmt_pkg::CH_ZERO + {3'd0, dec};
                done            = (r_dig == 2'd0) && (r_idx[1:0] == 2'd3);
            end
            ipfmt_pkg::BS_SEP: begin
                o_res.text_char = (r_cmd.kind == ipfmt_pkg::K_V6) ?
                                  ipfmt_pkg::CH_COLON : ipfmt_pkg::CH_DOT;
            end
            default: begin
            end
        endcase
        o_res.last_char = done;
        o_out_push      = step;
        o_cmd_pop       = i_cmd_valid &&
                          ((r_state == ipfmt_pkg::BS_IDLE) || (step && done));
    end

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_dig   = r_dig;
        n_cnt   = r_cnt;
        if (step) begin
            unique case (r_state)
                ipfmt_pkg::BS_PREFIX: begin
                    if (r_cnt != ipfmt_pkg::PRE_LAST) begin
                        n_cnt = r_cnt + 3'd1;
                    end else begin
                        n_state = ipfmt_pkg::BS_DEC;
                        n_idx   = 3'd0;
                        n_dig   = r_cmd.dstart[0];
                    end
                end
                ipfmt_pkg::BS_DCOLON: begin
                    if (r_cnt == 3'd0) begin
                        n_cnt = 3'd1;
                    end else if (!done) begin
                        n_state = ipfmt_pkg::BS_HEX;
                        n_idx   = r_cmd.run_end[2:0];
                        n_dig   = r_cmd.hstart[r_cmd.run_end[2:0]];
                    end
                end
                ipfmt_pkg::BS_HEX: begin
                    if (r_dig != 2'd0) begin
                        n_dig = r_dig - 2'd1;
                    end else if (!done) begin
                        n_idx = nxt;
                        if (r_cmd.run_ok && r_cmd.run_start == nxt) begin
                            n_state = ipfmt_pkg::BS_DCOLON;
                            n_cnt   = 3'd0;
                        end else begin
                            n_state = ipfmt_pkg::BS_SEP;
                        end
                    end
                end
                ipfmt_pkg::BS_DEC: begin
                    if (r_dig != 2'd0) begin
                        n_dig = r_dig - 2'd1;
                    end else if (!done) begin
                        n_state = ipfmt_pkg::BS_SEP;
                        n_idx   = nxt;
                    end
                end
                ipfmt_pkg::BS_SEP: begin
                    if (r_cmd.kind == ipfmt_pkg::K_V6) begin
                        n_state = ipfmt_pkg::BS_HEX;
                        n_dig   = r_cmd.hstart[r_idx];
                    end else begin
                        n_state = ipfmt_pkg::BS_DEC;
                        n_dig   = r_cmd.dstart[r_idx[1:0]];
                    end
                end
                default: begin
                end
            endcase
            if (done) n_state = ipfmt_pkg::BS_IDLE;
        end

        // load the next command
        if (o_cmd_pop) begin
            n_idx = 3'd0;
            n_cnt = 3'd0;
            n_dig = 2'd0;
            unique case (i_cmd.kind)
                ipfmt_pkg::K_V4: begin
                    n_state = ipfmt_pkg::BS_DEC;
                    n_dig   = i_cmd.dstart[0];
                end
                ipfmt_pkg::K_MAPPED: begin
                    n_state = ipfmt_pkg::BS_PREFIX;
                end
                ipfmt_pkg::K_V6: begin
                    if (i_cmd.run_ok && i_cmd.run_start == 3'd0) begin
                        n_state = ipfmt_pkg::BS_DCOLON;
                    end else begin
                        n_state = ipfmt_pkg::BS_HEX;
                        n_dig   = i_cmd.hstart[0];
                    end
                end
                default: n_state = ipfmt_pkg::BS_EMPTY;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipfmt_pkg::BS_IDLE;
            r_idx   <= '0;
            r_dig   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_dig   <= n_dig;
            r_cnt   <= n_cnt;
        end
    end

    // command payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
    end

endmodule

/* sv/ip_address_text_formatter_top.sv */
// The first character passes the command queue, the sequencer state and the result queue.
// Throughput: one character per cycle while the result queue is not full; an address yields
// 1 to 39 result entries, one per character of its text; the single-character sequencer sets this rate.
// Addresses queue up in a command queue while the sequencer works on an earlier one.
// Reset (synchronous, active low) empties both queues and idles the sequencer.
// ----------------------------------------------------------------------------
// IP address text formatter - top level
// Classifier, command queue, character sequencer and result queue.
// ----------------------------------------------------------------------------
module ip_address_text_formatter_top #(
    parameter int unsigned CMD_DEPTH = ipfmt_pkg::CMD_DEPTH,
    parameter int unsigned OUT_DEPTH = ipfmt_pkg::OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_address_family,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_text_char,
    output logic        o_last_char,
    output logic        o_empty_text
);

    localparam int unsigned CMD_W = $bits(ipfmt_pkg::t_cmd);
    localparam int unsigned RES_W = $bits(ipfmt_pkg::t_res);

    ipfmt_pkg::t_cmd cmd_in;
    ipfmt_pkg::t_cmd cmd_q;
    logic [CMD_W-1:0] cmd_raw;
    logic             cmd_empty;
    logic             cmd_pop;
    ipfmt_pkg::t_res  res_in;
    ipfmt_pkg::t_res  res_q;
    logic [RES_W-1:0] res_raw;
    logic             out_push;
    logic             out_full;

    // classify the incoming transaction
    ipfmt_front u_front (
        .i_address_family (i_address_family),
        .i_addr_high      (i_addr_high),
        .i_addr_low       (i_addr_low),
        .o_cmd            (cmd_in)
    );

    // command queue between classifier and sequencer
    ipfmt_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (CMD_W'(cmd_in)),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_raw),
        .o_empty (cmd_empty)
    );

    assign cmd_q = ipfmt_pkg::t_cmd'(cmd_raw);

    // character sequencer
    ipfmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_q),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_res       (res_in)
    );

    // result queue
    ipfmt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (RES_W'(res_in)),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (res_raw),
        .o_empty (empty)
    );

    assign res_q        = ipfmt_pkg::t_res'(res_raw);
    assign o_text_char  = res_q.text_char;
    assign o_last_char  = res_q.last_char;
    assign o_empty_text = res_q.empty_text;

    // sequencer never writes into a full result queue
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_push && out_full))
        else $error("sequencer wrote into a full result queue");

    // an empty-text result stands alone and carries a null character
    a_empty_text_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_empty_text) |-> (o_last_char && o_text_char == ipfmt_pkg::CH_NUL))
        else $error("empty-text result is not a lone null character");

    // a command is taken from the queue only when one is waiting
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("sequencer popped an empty command queue");

endmodule
